@@ sv/prr_pkg.sv @@
package prr_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned CfgWidth          = 16;
  localparam logic [CfgWidth-1:0] TimeoutReset = 16'hE600;

  typedef struct packed {
    logic pulse_out;
    logic input_echo;
  } result_t;

endpackage

@@ sv/prr_tracker.sv @@
module prr_tracker import prr_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                pin_level_i,
  input  logic [CfgWidth-1:0] timeout_limit_i,
  output result_t             result_o
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

  logic [COUNT_WIDTH-1:0] period_count_q, period_count_d;
  logic [COUNT_WIDTH-1:0] output_count_q, output_count_d;
  logic [COUNT_WIDTH-1:0] output_period_q, output_period_d;
  logic [COUNT_WIDTH-1:0] high_threshold_q, high_threshold_d;
  logic                   previous_level_q;
  logic                   output_level_q, output_level_d;

  logic [COUNT_WIDTH-1:0] oc_inc;
  logic [COUNT_WIDTH-1:0] pc_adv;
  logic [CmpWidth-1:0]    limit_ext;
  logic                   pc_hold;
  logic                   timed_out;
  logic                   rising;
  logic [COUNT_WIDTH:0]   scaled_sum;
  logic [COUNT_WIDTH-1:0] scaled;
  logic [COUNT_WIDTH-1:0] op_mid;
  logic [COUNT_WIDTH-1:0] ht_mid;

  assign limit_ext = CmpWidth'(timeout_limit_i);

  always_comb begin
    oc_inc         = output_count_q + 1'b1;
    output_count_d = oc_inc;
    output_level_d = output_level_q;
    if (oc_inc >= output_period_q) begin
      output_level_d = 1'b0;
      output_count_d = '0;
    end else if (oc_inc >= high_threshold_q) begin
      output_level_d = 1'b1;
    end
  end

  always_comb begin
    pc_hold   = (CmpWidth'(period_count_q) == limit_ext) || (&period_count_q);
    pc_adv    = pc_hold ? period_count_q : period_count_q + 1'b1;
    timed_out = (CmpWidth'(pc_adv) == limit_ext);
    op_mid    = timed_out ? '0 : output_period_q;
    ht_mid    = timed_out ? '0 : high_threshold_q;
    rising    = pin_level_i && !previous_level_q;

    scaled_sum = (COUNT_WIDTH+1)'(pc_adv) + (COUNT_WIDTH+1)'(pc_adv >> 5)
               + (COUNT_WIDTH+1)'(pc_adv >> 6) + (COUNT_WIDTH+1)'(pc_adv >> 7)
               + (COUNT_WIDTH+1)'(pc_adv >> 8);
    scaled     = scaled_sum[COUNT_WIDTH] ? '1 : scaled_sum[COUNT_WIDTH-1:0];

    if (rising) begin
      output_period_d  = timed_out ? op_mid : scaled;
      high_threshold_d = output_period_d >> 1;
      period_count_d   = '0;
    end else begin
      output_period_d  = op_mid;
      high_threshold_d = ht_mid;
      period_count_d   = pc_adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_count_q   <= '0;
      output_count_q   <= '0;
      output_period_q  <= '0;
      high_threshold_q <= '0;
      previous_level_q <= 1'b0;
      output_level_q   <= 1'b0;
    end else if (accept_i) begin
      period_count_q   <= period_count_d;
      output_count_q   <= output_count_d;
      output_period_q  <= output_period_d;
      high_threshold_q <= high_threshold_d;
      previous_level_q <= pin_level_i;
      output_level_q   <= output_level_d;
    end
  end

  assign result_o.pulse_out  = output_level_d;
  assign result_o.input_echo = pin_level_i;

endmodule

@@ sv/prr_out_buf.sv @@
module prr_out_buf import prr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    take;
  logic    push;

  assign take = main_valid_q && !out_stall_i;
  assign push = in_valid_i && !skid_valid_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q || take) begin
        main_d       = in_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

@@ sv/pulse_period_rescaler_core.sv @@
// Channel   Handshake                  Word
// input     in_valid_i / in_stall_o    pin_level_i
// output    out_valid_o / out_stall_i  pulse_out_o, input_echo_o
// config    cfg_wr_en_i                cfg_wr_data_i (timeout limit)
//
// One word is taken per cycle while in_stall_o is low; its result is registered.
// The state update for a tick is a single pass of shift-add and compare logic.
// A two-entry output buffer lets one further word in while a result is stalled.
// Reset clears all counters and periods and loads the timeout limit with 0xE600.
module pulse_period_rescaler_core import prr_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                pin_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                pulse_out_o,
  output logic                input_echo_o,
  input  logic                cfg_wr_en_i,
  input  logic [CfgWidth-1:0] cfg_wr_data_i
);

  logic [CfgWidth-1:0] timeout_limit_q;
  logic                accept;
  result_t             step_result;
  result_t             out_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_limit_q <= TimeoutReset;
    end else if (cfg_wr_en_i) begin
      timeout_limit_q <= cfg_wr_data_i;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  prr_tracker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pin_level_i    (pin_level_i),
    .timeout_limit_i(timeout_limit_q),
    .result_o       (step_result)
  );

  prr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (step_result),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_result)
  );

  assign pulse_out_o  = out_result.pulse_out;
  assign input_echo_o = out_result.input_echo;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=>
      (out_valid_o && input_echo_o == $past(pin_level_i)))
    else $error("accepted word did not reach an empty output register");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prr_pkg::*;

  localparam int unsigned CW          = CountWidthDefault;
  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned BusyPct     = 36;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomTicks = 800;
  localparam int unsigned PhaseTicks  = 150;

  typedef enum logic {RowTicks, RowLimit} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        pin;
    logic [31:0] count;
    logic        typed;
    logic        pulse;
  } row_t;

  // Only the rows straight after reset carry a typed result; the output is
  // held low there because no period has been captured yet.
  localparam int unsigned DirectedRows = 29;
  localparam row_t Directed [DirectedRows] = '{
    '{RowTicks, 1'b0, 32'd3,     1'b1, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b1, 1'b0},
    '{RowTicks, 1'b1, 32'd4,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd4,     1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd20,    1'b0, 1'b0},
    '{RowLimit, 1'b0, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd3,     1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd2,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowLimit, 1'b0, 32'd0,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd2,     1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd3,     1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowLimit, 1'b0, 32'd65535, 1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd200,   1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowLimit, 1'b0, 32'd40,    1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd60,    1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd10,    1'b0, 1'b0},
    '{RowTicks, 1'b1, 32'd1,     1'b0, 1'b0},
    '{RowTicks, 1'b0, 32'd30,    1'b0, 1'b0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                pin_level_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                pulse_out_o;
  logic                input_echo_o;
  logic                cfg_wr_en_i   = 1'b0;
  logic [CfgWidth-1:0] cfg_wr_data_i = '0;

  pulse_period_rescaler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pin_level_i   (pin_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pulse_out_o   (pulse_out_o),
    .input_echo_o  (input_echo_o),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mirror of the block's state.
  logic [CfgWidth-1:0] lim_q       = TimeoutReset;
  logic [CW-1:0]       tick_cnt    = '0;
  logic [CW-1:0]       wave_cnt    = '0;
  logic [CW-1:0]       wave_period = '0;
  logic [CW-1:0]       wave_half   = '0;
  logic                last_pin    = 1'b0;
  logic                wave_level  = 1'b0;

  result_t     expected_pulses [$];
  int unsigned mismatches   = 0;
  int unsigned ticks_sent   = 0;
  int unsigned idle_pct     = BusyPct;
  logic        hold_request = 1'b0;

  function automatic result_t rescale_tick(input logic pin);
    logic [CW:0] scaled;
    logic        expired;
    result_t     r;
    wave_cnt = wave_cnt + 1'b1;
    if (wave_cnt >= wave_period) begin
      wave_level = 1'b0;
      wave_cnt   = '0;
    end else if (wave_cnt >= wave_half) begin
      wave_level = 1'b1;
    end
    if (tick_cnt != lim_q && tick_cnt != '1) begin
      tick_cnt = tick_cnt + 1'b1;
    end
    expired = (tick_cnt == lim_q);
    if (expired) begin
      wave_period = '0;
      wave_half   = '0;
    end
    if (pin && !last_pin) begin
      if (!expired) begin
        scaled = (CW+1)'(tick_cnt) + (CW+1)'(tick_cnt >> 5) + (CW+1)'(tick_cnt >> 6)
                 + (CW+1)'(tick_cnt >> 7) + (CW+1)'(tick_cnt >> 8);
        wave_period = scaled[CW] ? '1 : scaled[CW-1:0];
      end
      wave_half = wave_period >> 1;
      tick_cnt  = '0;
    end
    last_pin     = pin;
    r.pulse_out  = wave_level;
    r.input_echo = pin;
    return r;
  endfunction

  task automatic send_tick(input logic pin, input logic typed, input logic pulse);
    result_t predicted;
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    do @(posedge clk_i); while (in_stall_o);
    predicted = rescale_tick(pin);
    if (typed) begin
      predicted.pulse_out  = pulse;
      predicted.input_echo = pin;
    end
    expected_pulses.push_back(predicted);
    ticks_sent++;
  endtask

  // The timeout limit is only changed once every outstanding word has left.
  task automatic load_timeout(input logic [CfgWidth-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    lim_q = value;
  endtask

  task automatic report(input string field, input logic want, input logic got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
  endtask

  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end
      out_stall_i <= (idle_pct != 0 && $urandom_range(99, 0) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pulses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual pulse %0b echo %0b",
                 $time, pulse_out_o, input_echo_o);
      end else begin
        want = expected_pulses.pop_front();
        if (pulse_out_o !== want.pulse_out) report("pulse_out", want.pulse_out, pulse_out_o);
        if (input_echo_o !== want.input_echo) begin
          report("input_echo", want.input_echo, input_echo_o);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned r;
    int unsigned low_len;
    int unsigned high_len;
    int unsigned reps;
    int unsigned phase;
    int unsigned phase_end;
    int unsigned random_end;
    logic [CfgWidth-1:0] limit;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i]) begin
      if (Directed[i].kind == RowLimit) begin
        load_timeout(Directed[i].count[CfgWidth-1:0]);
      end else begin
        idle_pct = (Directed[i].count > 100) ? 0 : BusyPct;
        for (n = 0; n < Directed[i].count; n++) begin
          send_tick(Directed[i].pin, Directed[i].typed, Directed[i].pulse);
        end
      end
    end

    phase      = 0;
    random_end = ticks_sent + RandomTicks;
    while (ticks_sent < random_end) begin
      case ($urandom_range(9, 0))
        0:       limit = '0;
        1:       limit = '1;
        2:       limit = CfgWidth'($urandom_range(8, 1));
        3:       limit = CfgWidth'($urandom);
        default: limit = CfgWidth'($urandom_range(600, 20));
      endcase
      load_timeout(limit);
      idle_pct = (phase == 3) ? 0 : BusyPct;
      if (phase == 0) hold_request = 1'b1;
      phase_end = ticks_sent + PhaseTicks;
      while (ticks_sent < phase_end) begin
        if ($urandom_range(99, 0) < 20) begin
          for (n = $urandom_range(20, 1); n != 0; n--) begin
            send_tick(1'($urandom_range(1, 0)), 1'b0, 1'b0);
          end
        end else begin
          low_len  = ($urandom_range(9, 0) == 0) ? $urandom_range(400, 1)
                                                 : $urandom_range(40, 1);
          high_len = $urandom_range(40, 1);
          reps     = $urandom_range(6, 1);
          for (r = 0; r < reps; r++) begin
            for (n = 0; n < low_len; n++) send_tick(1'b0, 1'b0, 1'b0);
            for (n = 0; n < high_len; n++) send_tick(1'b1, 1'b0, 1'b0);
          end
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    idle_pct = BusyPct;
    while (expected_pulses.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/prr_pkg.sv
sv/prr_tracker.sv
sv/prr_out_buf.sv
sv/pulse_period_rescaler_core.sv
tb/tb_top.sv
